FILE: hw/rtl/mfa_pkg.sv
`default_nettype none
package mfa_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
   localparam int MUL_WIDTH     = 2 * OPERAND_WIDTH;
   localparam int WIDE_WIDTH    = 64;
   localparam int WHOLE_WIDTH   = 63;
   localparam int RNUM_WIDTH    = 48;
   localparam int RDEN_WIDTH    = 47;

   localparam logic [1:0] KIND_ADD     = 2'd0;
   localparam logic [1:0] KIND_MUL     = 2'd1;
   localparam logic [1:0] KIND_DIV     = 2'd2;
   localparam logic [1:0] KIND_COMPARE = 2'd3;

   localparam logic [1:0] ORDER_LESS    = 2'd0;
   localparam logic [1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [1:0] ORDER_GREATER = 2'd2;

   typedef struct packed {
      logic [1:0]                        kind;
      logic signed [OPERAND_WIDTH-1:0]   a_integer;
      logic signed [OPERAND_WIDTH-1:0]   a_numerator;
      logic [DEN_WIDTH-1:0]              a_denominator;
      logic signed [OPERAND_WIDTH-1:0]   b_integer;
      logic signed [OPERAND_WIDTH-1:0]   b_numerator;
      logic [DEN_WIDTH-1:0]              b_denominator;
   } req_type;

   typedef struct packed {
      logic signed [WHOLE_WIDTH-1:0] result_whole;
      logic signed [RNUM_WIDTH-1:0]  result_numerator;
      logic [RDEN_WIDTH-1:0]         result_denominator;
      logic [1:0]                    order;
      logic                          divide_by_zero;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hw/rtl/mixed_fraction_arithmetic.sv
// Sequence: every word first runs 5 multiplier steps; compare and divide-by-zero words then go
//   to the output. Arithmetic words then take a 64-step quotient and, when the remainder is not
//   zero, a binary GCD and two 64-step exact divisions, all on one multiplier and one divider.
// Throughput: one word at a time; req_ready is high only while the sequencer is idle.
// Reset: synchronous, active high; clears the sequencer and the output valid, no clearing pass.
`default_nettype none
module mixed_fraction_arithmetic
   import mfa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int DIV_STEPS = WIDE_WIDTH;
   localparam int CNT_WIDTH = $clog2(DIV_STEPS);

   // one-hot sequencer
   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_MUL  = 11'b000_0000_0010,
      S_PREP = 11'b000_0000_0100,
      S_DIVQ = 11'b000_0000_1000,
      S_POST = 11'b000_0001_0000,
      S_GCD  = 11'b000_0010_0000,
      S_DIVN = 11'b000_0100_0000,
      S_NUMS = 11'b000_1000_0000,
      S_DIVD = 11'b001_0000_0000,
      S_DENS = 11'b010_0000_0000,
      S_FIN  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   req_type   op_ff, op_in;
   logic [2:0] mstep_ff, mstep_in;
   logic signed [MUL_WIDTH-1:0]  na_ff, na_in, nb_ff, nb_in;
   logic signed [WIDE_WIDTH-1:0] num_ff, num_in, den_ff, den_in;
   logic signed [WIDE_WIDTH-1:0] whole_ff, whole_in;
   logic neg_ff, neg_in;
   logic [WIDE_WIDTH-1:0] gx_ff, gx_in, gy_ff, gy_in, rr_ff, rr_in, dd_ff, dd_in;
   logic [WIDE_WIDTH-1:0] div_rem_ff, div_rem_in, div_quo_ff, div_quo_in, div_v_ff, div_v_in;
   logic [CNT_WIDTH-1:0]  div_cnt_ff, div_cnt_in;
   logic signed [WIDE_WIDTH-1:0] res_whole_ff, res_whole_in, res_num_ff, res_num_in;
   logic [WIDE_WIDTH-1:0] res_den_ff, res_den_in;
   logic [1:0] res_order_ff, res_order_in;
   logic res_dz_ff, res_dz_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   // operand views, zero denominator reads as one
   logic [DEN_WIDTH-1:0] ad_eff, bd_eff;
   logic signed [MUL_WIDTH-1:0] ai32, an32, ad32, bi32, bn32, bd32;
   assign ad_eff = (op_ff.a_denominator == '0) ? DEN_WIDTH'(1) : op_ff.a_denominator;
   assign bd_eff = (op_ff.b_denominator == '0) ? DEN_WIDTH'(1) : op_ff.b_denominator;
   assign ai32 = MUL_WIDTH'(op_ff.a_integer);
   assign an32 = MUL_WIDTH'(op_ff.a_numerator);
   assign bi32 = MUL_WIDTH'(op_ff.b_integer);
   assign bn32 = MUL_WIDTH'(op_ff.b_numerator);
   assign ad32 = $signed({{(MUL_WIDTH-DEN_WIDTH){1'b0}}, ad_eff});
   assign bd32 = $signed({{(MUL_WIDTH-DEN_WIDTH){1'b0}}, bd_eff});

   // shared multiplier
   logic signed [MUL_WIDTH-1:0]  mul_a, mul_b;
   logic signed [WIDE_WIDTH-1:0] prod;
   assign prod = WIDE_WIDTH'(mul_a) * WIDE_WIDTH'(mul_b);

   always_comb begin
      mul_a = ai32;
      mul_b = ad32;
      unique case (mstep_ff)
         3'd0: begin
            mul_a = ai32; mul_b = ad32;
         end
         3'd1: begin
            mul_a = bi32; mul_b = bd32;
         end
         3'd2: begin
            if (op_ff.kind == KIND_ADD) begin
               mul_a = an32; mul_b = bd32;
            end else if (op_ff.kind == KIND_MUL) begin
               mul_a = na_ff; mul_b = nb_ff;
            end else begin
               mul_a = na_ff; mul_b = bd32;
            end
         end
         3'd3: begin
            unique case (op_ff.kind)
               KIND_ADD: begin mul_a = bn32;  mul_b = ad32;  end
               KIND_MUL: begin mul_a = ad32;  mul_b = bd32;  end
               KIND_DIV: begin mul_a = ad32;  mul_b = nb_ff; end
               default:  begin mul_a = nb_ff; mul_b = ad32;  end
            endcase
         end
         default: begin
            mul_a = ad32; mul_b = bd32;
         end
      endcase
   end

   // shared restoring divider, one quotient bit a cycle
   logic [WIDE_WIDTH-1:0] div_shift, div_rem_next, div_quo_next;
   logic div_ge, div_last;
   assign div_shift    = {div_rem_ff[WIDE_WIDTH-2:0], div_quo_ff[WIDE_WIDTH-1]};
   assign div_ge       = div_shift >= div_v_ff;
   assign div_rem_next = div_ge ? div_shift - div_v_ff : div_shift;
   assign div_quo_next = {div_quo_ff[WIDE_WIDTH-2:0], div_ge};
   assign div_last     = div_cnt_ff == CNT_WIDTH'(DIV_STEPS - 1);

   // magnitudes for the split
   logic [WIDE_WIDTH-1:0] num_mag, den_mag;
   assign num_mag = num_ff[WIDE_WIDTH-1] ? WIDE_WIDTH'(-num_ff) : WIDE_WIDTH'(num_ff);
   assign den_mag = den_ff[WIDE_WIDTH-1] ? WIDE_WIDTH'(-den_ff) : WIDE_WIDTH'(den_ff);

   logic signed [WIDE_WIDTH-1:0] q_signed;
   assign q_signed = neg_ff ? -$signed(div_quo_ff) : $signed(div_quo_ff);

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      mstep_in     = mstep_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      whole_in     = whole_ff;
      neg_in       = neg_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      rr_in        = rr_ff;
      dd_in        = dd_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_v_in     = div_v_ff;
      div_cnt_in   = div_cnt_ff;
      res_whole_in = res_whole_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      res_order_in = res_order_ff;
      res_dz_in    = res_dz_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_data;
               mstep_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            mstep_in = mstep_ff + 3'd1;
            unique case (mstep_ff)
               3'd0: na_in = prod[MUL_WIDTH-1:0] + an32;
               3'd1: nb_in = prod[MUL_WIDTH-1:0] + bn32;
               3'd2: num_in = prod;
               3'd3: begin
                  if (op_ff.kind == KIND_ADD) num_in = num_ff + prod;
                  else den_in = prod;
               end
               default: begin
                  if (op_ff.kind == KIND_ADD) den_in = prod;
                  state_in = S_PREP;
               end
            endcase
         end
         S_PREP: begin
            res_whole_in = '0;
            res_num_in   = '0;
            res_den_in   = WIDE_WIDTH'(1);
            res_order_in = ORDER_LESS;
            res_dz_in    = 1'b0;
            if (op_ff.kind == KIND_COMPARE) begin
               if (num_ff < den_ff) res_order_in = ORDER_LESS;
               else if (num_ff == den_ff) res_order_in = ORDER_EQUAL;
               else res_order_in = ORDER_GREATER;
               state_in = S_FIN;
            end else if (op_ff.kind == KIND_DIV && nb_ff == '0) begin
               res_dz_in = 1'b1;
               state_in  = S_FIN;
            end else begin
               // a negative denominator flips the quotient sign
               neg_in     = num_ff[WIDE_WIDTH-1] ^ den_ff[WIDE_WIDTH-1];
               div_quo_in = num_mag;
               div_rem_in = '0;
               div_v_in   = (den_mag == '0) ? WIDE_WIDTH'(1) : den_mag;
               div_cnt_in = '0;
               whole_in   = (op_ff.kind == KIND_ADD)
                            ? WIDE_WIDTH'(op_ff.a_integer) + WIDE_WIDTH'(op_ff.b_integer)
                            : '0;
               state_in   = S_DIVQ;
            end
         end
         S_DIVQ: begin
            div_rem_in = div_rem_next;
            div_quo_in = div_quo_next;
            div_cnt_in = div_cnt_ff + CNT_WIDTH'(1);
            if (div_last) state_in = S_POST;
         end
         S_POST: begin
            res_whole_in = whole_ff + q_signed;
            if (div_rem_ff == '0) begin
               res_num_in = '0;
               res_den_in = div_v_ff;
               state_in   = S_FIN;
            end else begin
               gx_in    = div_rem_ff;
               gy_in    = div_v_ff;
               rr_in    = div_rem_ff;
               dd_in    = div_v_ff;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            // binary GCD; common factors of two come off the operands at once
            priority if (gx_ff == '0) begin
               div_quo_in = rr_ff;
               div_rem_in = '0;
               div_v_in   = gy_ff;
               div_cnt_in = '0;
               state_in   = S_DIVN;
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               rr_in = rr_ff >> 1;
               dd_in = dd_ff >> 1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff >= gy_ff) begin
               gx_in = gx_ff - gy_ff;
            end else begin
               gy_in = gy_ff - gx_ff;
            end
         end
         S_DIVN: begin
            div_rem_in = div_rem_next;
            div_quo_in = div_quo_next;
            div_cnt_in = div_cnt_ff + CNT_WIDTH'(1);
            if (div_last) state_in = S_NUMS;
         end
         S_NUMS: begin
            res_num_in = q_signed;
            div_quo_in = dd_ff;
            div_rem_in = '0;
            div_cnt_in = '0;
            state_in   = S_DIVD;
         end
         S_DIVD: begin
            div_rem_in = div_rem_next;
            div_quo_in = div_quo_next;
            div_cnt_in = div_cnt_ff + CNT_WIDTH'(1);
            if (div_last) state_in = S_DENS;
         end
         S_DENS: begin
            res_den_in = div_quo_ff;
            state_in   = S_FIN;
         end
         S_FIN: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.result_whole       = res_whole_ff[WHOLE_WIDTH-1:0];
               rsp_in.result_numerator   = res_num_ff[RNUM_WIDTH-1:0];
               rsp_in.result_denominator = res_den_ff[RDEN_WIDTH-1:0];
               rsp_in.order              = res_order_ff;
               rsp_in.divide_by_zero     = res_dz_ff;
               rsp_valid_in              = 1'b1;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mstep_ff     <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mstep_ff     <= mstep_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      na_ff        <= na_in;
      nb_ff        <= nb_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      whole_ff     <= whole_in;
      neg_ff       <= neg_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      rr_ff        <= rr_in;
      dd_ff        <= dd_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_v_ff     <= div_v_in;
      res_whole_ff <= res_whole_in;
      res_num_ff   <= res_num_in;
      res_den_ff   <= res_den_in;
      res_order_ff <= res_order_in;
      res_dz_ff    <= res_dz_in;
      rsp_ff       <= rsp_in;
   end

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer took a word while busy");

   a_dz_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |->
         rsp_data.result_whole == '0 && rsp_data.result_numerator == '0 &&
         rsp_data.result_denominator == RDEN_WIDTH'(1))
      else $error("divide-by-zero word carries a result");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.result_denominator != '0)
      else $error("zero denominator on output");

   a_gcd_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GCD |-> gy_ff != '0)
      else $error("GCD lost its divisor");

endmodule
`default_nettype wire
